/* design/ldub_pkg.sv */
// Package for the landmark distance upper bound block.
// Command codes, configuration register indexes and the accumulator control type.
// No dependencies.
`default_nettype none

package ldub_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_LOAD_TO   = 2'd0;
    localparam logic [1:0] CMD_LOAD_FROM = 2'd1;
    localparam logic [1:0] CMD_QUERY     = 2'd2;

    // configuration register indexes
    localparam logic REG_LANDMARKS_USED = 1'b0;
    localparam logic REG_DEFAULT_BOUND  = 1'b1;

    localparam int CMD_W   = 2;
    localparam int VTX_W   = 10;
    localparam int LM_W    = 4;
    localparam int DIN_W   = 16;
    localparam int BOUND_W = 16;
    localparam int LMU_W   = 5;
    localparam int CFG_W   = 16;

    localparam logic [LMU_W-1:0] LANDMARKS_USED_RST = 5'd16;

    // control from the sequencer to the min/add unit
    typedef struct packed {
        logic init;   // load the running minimum with the default bound
        logic en;     // fold one pair of table reads into the minimum
    } t_acc_ctl;

endpackage

`default_nettype wire

/* design/ldub_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ldub_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/ldub_minacc.sv */
// Shared add/compare unit: sums one pair of known distances and keeps the running minimum.
// Depends on ldub_pkg.
`default_nettype none

module ldub_minacc
    import ldub_pkg::*;
#(
    parameter int DIST_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire t_acc_ctl             i_ctl,
    input  wire logic [BOUND_W-1:0]   i_init_bound,
    input  wire logic [DIST_BITS-1:0] i_dist_a,
    input  wire logic [DIST_BITS-1:0] i_dist_b,
    output logic      [BOUND_W-1:0]   o_best
);

    localparam int CMP_W = (DIST_BITS > BOUND_W) ? DIST_BITS : BOUND_W;

    logic                 known;
    logic [DIST_BITS-1:0] sum;
    logic                 less;
    logic [BOUND_W-1:0]   r_best;
    logic [BOUND_W-1:0]   n_best;

    // both operands non-negative, so the sum fits in DIST_BITS unsigned bits
    assign known = ~i_dist_a[DIST_BITS-1] & ~i_dist_b[DIST_BITS-1];
    assign sum   = {1'b0, i_dist_a[DIST_BITS-2:0]} + {1'b0, i_dist_b[DIST_BITS-2:0]};
    assign less  = CMP_W'(sum) < CMP_W'(r_best);

    always_comb begin
        n_best = r_best;
        if (i_ctl.init) begin
            n_best = i_init_bound;
        end else if (i_ctl.en && known && less) begin
            n_best = BOUND_W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
    end

    assign o_best = r_best;

endmodule

`default_nettype wire

/* design/landmark_distance_upper_bound_top.sv */
// Top level of the landmark distance upper bound block: stream ports, sequencer, tables.
// Depends on ldub_pkg, ldub_ram and ldub_minacc.
`default_nettype none

// Load words (tuser 0 or 1) write one entry of the vertex-to-landmark or the
// landmark-to-vertex table and give no output word. A query word (tuser 2)
// scans min(landmarks_used, MAX_LANDMARKS) landmark columns, one per cycle,
// reading one entry from each table per cycle through the single read port of
// each table RAM, and returns the smallest known two-leg distance capped at
// default_bound. A query with a vertex out of range or no landmark to scan skips
// the scan. tready is low until the query's result enters the output register.
// One finished result can wait in the output register while the next word is
// taken. Table entries must be written before they are read.
module landmark_distance_upper_bound_top
    import ldub_pkg::*;
#(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_LANDMARKS = 16,
    parameter int DIST_BITS     = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [39:0]        s_axis_tdata,  // vertex[9:0], landmark[13:10],
                                                   // distance[29:14], end_vertex[39:30]
    input  wire logic [CMD_W-1:0]   s_axis_tuser,  // cmd[1:0]
    // output stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [15:0]        m_axis_tdata,  // bound[15:0]
    // configuration
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata
);

    localparam int DEPTH = MAX_VERTICES * MAX_LANDMARKS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IDX_W = $clog2(MAX_LANDMARKS + 1);
    localparam int DEF_BOUND = (MAX_VERTICES + 1 > 65535) ? 65535 : MAX_VERTICES + 1;
    localparam logic [BOUND_W-1:0] DEFAULT_BOUND_RST = BOUND_W'(DEF_BOUND);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // input fields
    logic [CMD_W-1:0]        in_cmd;
    logic [VTX_W-1:0]        in_vertex;
    logic [LM_W-1:0]         in_landmark;
    logic signed [DIN_W-1:0] in_distance;
    logic [VTX_W-1:0]        in_end_vertex;

    assign in_cmd        = s_axis_tuser;
    assign in_vertex     = s_axis_tdata[9:0];
    assign in_landmark   = s_axis_tdata[13:10];
    assign in_distance   = s_axis_tdata[29:14];
    assign in_end_vertex = s_axis_tdata[39:30];

    // configuration registers
    logic [LMU_W-1:0]   r_lm_used;
    logic [BOUND_W-1:0] r_default_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lm_used       <= LANDMARKS_USED_RST;
            r_default_bound <= DEFAULT_BOUND_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_LANDMARKS_USED: r_lm_used       <= i_cfg_wdata[LMU_W-1:0];
                REG_DEFAULT_BOUND:  r_default_bound <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer state
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic [AW-1:0]      r_base_a, n_base_a;
    logic [AW-1:0]      r_base_b, n_base_b;
    logic               r_rd_vld, n_rd_vld;
    logic               r_out_valid, n_out_valid;
    logic [BOUND_W-1:0] r_out_bound, n_out_bound;

    logic               s_fire;
    logic               vtx_ok, endv_ok, lm_ok;
    logic [AW-1:0]      vtx_base, endv_base, load_addr;
    logic [IDX_W-1:0]   scan_cnt;
    logic [DIST_BITS-1:0] wr_dist;
    logic               we_to, we_from;
    logic [AW-1:0]      rd_addr_a, rd_addr_b;
    logic [DIST_BITS-1:0] rd_to, rd_from;
    t_acc_ctl           acc_ctl;
    logic [BOUND_W-1:0] best;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid & s_axis_tready;

    assign vtx_ok    = 32'(in_vertex) < MAX_VERTICES;
    assign endv_ok   = 32'(in_end_vertex) < MAX_VERTICES;
    assign lm_ok     = 32'(in_landmark) < MAX_LANDMARKS;
    assign vtx_base  = AW'(32'(in_vertex) * MAX_LANDMARKS);
    assign endv_base = AW'(32'(in_end_vertex) * MAX_LANDMARKS);
    assign load_addr = vtx_base + AW'(in_landmark);
    assign scan_cnt  = (32'(r_lm_used) > MAX_LANDMARKS) ? IDX_W'(MAX_LANDMARKS)
                                                         : IDX_W'(r_lm_used);
    // stored value keeps its low DIST_BITS bits of the sign-extended input
    assign wr_dist   = DIST_BITS'(in_distance);

    assign we_to   = s_fire && (in_cmd == CMD_LOAD_TO) && vtx_ok && lm_ok;
    assign we_from = s_fire && (in_cmd == CMD_LOAD_FROM) && vtx_ok && lm_ok;

    assign rd_addr_a = r_base_a + AW'(r_idx);
    assign rd_addr_b = r_base_b + AW'(r_idx);

    assign acc_ctl.init = s_fire && (in_cmd == CMD_QUERY);
    assign acc_ctl.en   = r_rd_vld;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_base_a    = r_base_a;
        n_base_b    = r_base_b;
        n_rd_vld    = 1'b0;
        n_out_valid = r_out_valid;
        n_out_bound = r_out_bound;

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_fire && (in_cmd == CMD_QUERY)) begin
                    n_idx    = '0;
                    n_cnt    = scan_cnt;
                    n_base_a = vtx_base;
                    n_base_b = endv_base;
                    if (vtx_ok && endv_ok && (scan_cnt != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // read issued this cycle, folded into the minimum next cycle
                n_rd_vld = 1'b1;
                n_idx    = r_idx + IDX_W'(1);
                if (r_idx == r_cnt - IDX_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_bound = best;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_base_a    <= n_base_a;
        r_base_b    <= n_base_b;
        r_out_bound <= n_out_bound;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_bound;

    ldub_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_to_table (
        .i_clk   (i_clk),
        .i_we    (we_to),
        .i_waddr (load_addr),
        .i_wdata (wr_dist),
        .i_raddr (rd_addr_a),
        .o_rdata (rd_to)
    );

    ldub_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_from_table (
        .i_clk   (i_clk),
        .i_we    (we_from),
        .i_waddr (load_addr),
        .i_wdata (wr_dist),
        .i_raddr (rd_addr_b),
        .o_rdata (rd_from)
    );

    ldub_minacc #(
        .DIST_BITS (DIST_BITS)
    ) u_minacc (
        .i_clk        (i_clk),
        .i_ctl        (acc_ctl),
        .i_init_bound (r_default_bound),
        .i_dist_a     (rd_to),
        .i_dist_b     (rd_from),
        .o_best       (best)
    );

    // table reads are only folded in during the scan and drain states
    a_rd_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("table read outside a scan");

    // an accepted query always leaves idle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && in_cmd == CMD_QUERY) |=> (r_state != S_IDLE))
        else $error("query accepted but sequencer stayed idle");

    // a new answer never exceeds the default bound
    a_bound_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> (m_axis_tdata <= r_default_bound))
        else $error("answer above default bound");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

endmodule

`default_nettype wire

/* tb/sv/tb_landmark_distance_upper_bound_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for landmark_distance_upper_bound_top: table loads, queries, register phases.
// Depends on ldub_pkg and the block's RTL; predicts every bound word and checks it in order.

module tb_landmark_distance_upper_bound_top;
    import ldub_pkg::*;

    localparam int VERTICES          = 1024;
    localparam int LANDMARKS         = 16;
    localparam int TABLE_DEPTH       = VERTICES * LANDMARKS;
    localparam int ITEMS_TARGET      = 1900;
    localparam int CALM_AFTER        = 1600;
    localparam int DRAIN_CYCLES      = 24;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int MAX_REPORTS       = 10;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [BOUND_W-1:0] DEFAULT_BOUND_RST = BOUND_W'(VERTICES + 1);

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [VTX_W-1:0] end_vertex;
        logic [DIN_W-1:0] distance;
        logic [LM_W-1:0]  landmark;
        logic [VTX_W-1:0] vertex;
    } t_ldub_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata = '0;   // vertex[9:0], landmark[13:10],
                                             // distance[29:14], end_vertex[39:30]
    logic [CMD_W-1:0]   s_axis_tuser = '0;   // cmd[1:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;        // bound[15:0]
    logic               i_cfg_wr_en = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;

    landmark_distance_upper_bound_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [DIN_W-1:0] to_dist   [TABLE_DEPTH];
    logic signed [DIN_W-1:0] from_dist [TABLE_DEPTH];
    logic [LMU_W-1:0]        lm_used = LANDMARKS_USED_RST;
    logic [BOUND_W-1:0]      bound_default = DEFAULT_BOUND_RST;

    t_ldub_word          pending_words[$];
    logic [BOUND_W-1:0]  expected_bounds[$];

    // rows known to be fully written, so queries never read an unwritten entry
    bit  to_row_ready   [VERTICES];
    bit  from_row_ready [VERTICES];
    int  to_ready[$];
    int  from_ready[$];

    int  item_total = 0;
    int  error_count = 0;
    int  stall_cycles = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    bit  idling_on = 1'b1;

    function automatic logic [BOUND_W-1:0] landmark_bound(logic [VTX_W-1:0] src,
                                                          logic [VTX_W-1:0] dst);
        int cols;
        int best;
        int a;
        int b;
        cols = (int'(lm_used) > LANDMARKS) ? LANDMARKS : int'(lm_used);
        best = int'(bound_default);
        for (int c = 0; c < cols; c++) begin
            a = to_dist[int'(src) * LANDMARKS + c];
            b = from_dist[int'(dst) * LANDMARKS + c];
            if (a >= 0 && b >= 0 && a + b < best)
                best = a + b;
        end
        return best[BOUND_W-1:0];
    endfunction

    function automatic void apply_word(t_ldub_word w);
        int idx;
        idx = int'(w.vertex) * LANDMARKS + int'(w.landmark);
        case (w.cmd)
            CMD_LOAD_TO:   to_dist[idx] = w.distance;
            CMD_LOAD_FROM: from_dist[idx] = w.distance;
            CMD_QUERY: begin
                expected_bounds.insert(expected_bounds.size(),
                                       landmark_bound(w.vertex, w.end_vertex));
            end
            default: ;
        endcase
    endfunction

    function automatic void push_word(logic [CMD_W-1:0] cmd, int vtx, int lm,
                                      logic [DIN_W-1:0] dist_val, int endv);
        t_ldub_word w;
        w.cmd        = cmd;
        w.vertex     = VTX_W'(vtx);
        w.landmark   = LM_W'(lm);
        w.distance   = dist_val;
        w.end_vertex = VTX_W'(endv);
        pending_words.insert(pending_words.size(), w);
        item_total++;
    endfunction

    function automatic logic [DIN_W-1:0] rand_distance();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000 | 16'($urandom);  // unknown
        if (r == 1) return 16'h8000;
        if (r == 2) return 16'h7FFF;
        if (r == 3) return 16'h0000;
        if (r <= 6) return 16'($urandom_range(1, 600));
        return 16'($urandom_range(0, 32767));
    endfunction

    function automatic int rand_vertex();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 0;
        if (r == 1) return VERTICES - 1;
        return $urandom_range(0, VERTICES - 1);
    endfunction

    function automatic void queue_load(logic [CMD_W-1:0] cmd, int vtx, int lm,
                                       logic [DIN_W-1:0] dist_val);
        push_word(cmd, vtx, lm, dist_val, $urandom_range(0, VERTICES - 1));
    endfunction

    function automatic void queue_query(int src, int dst);
        push_word(CMD_QUERY, src, $urandom_range(0, LANDMARKS - 1), 16'($urandom), dst);
    endfunction

    // write all columns of one row in shuffled order
    function automatic void fill_row(logic [CMD_W-1:0] cmd, int vtx);
        int order[LANDMARKS];
        int j;
        int t;
        for (int i = 0; i < LANDMARKS; i++) order[i] = i;
        for (int i = LANDMARKS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < LANDMARKS; i++)
            queue_load(cmd, vtx, order[i], rand_distance());
        if (cmd == CMD_LOAD_TO && !to_row_ready[vtx]) begin
            to_row_ready[vtx] = 1'b1;
            to_ready.insert(to_ready.size(), vtx);
        end else if (cmd == CMD_LOAD_FROM && !from_row_ready[vtx]) begin
            from_row_ready[vtx] = 1'b1;
            from_ready.insert(from_ready.size(), vtx);
        end
    endfunction

    function automatic int pick_to();
        return to_ready[$urandom_range(0, to_ready.size() - 1)];
    endfunction

    function automatic int pick_from();
        return from_ready[$urandom_range(0, from_ready.size() - 1)];
    endfunction

    // wait until the block has nothing in flight, then let it settle
    task automatic settle();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_bounds.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_LANDMARKS_USED)
            lm_used = val[LMU_W-1:0];
        else
            bound_default = val;
        @(negedge i_clk);
    endtask

    // input side
    always @(posedge i_clk) begin : word_driver
        t_ldub_word w;
        logic       next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                w.cmd        = s_axis_tuser;
                w.vertex     = s_axis_tdata[9:0];
                w.landmark   = s_axis_tdata[13:10];
                w.distance   = s_axis_tdata[29:14];
                w.end_vertex = s_axis_tdata[39:30];
                apply_word(w);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                next_valid = 1'b0;
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    next_valid = 1'b1;
                    s_axis_tuser <= w.cmd;
                    s_axis_tdata <= {w.end_vertex, w.distance, w.landmark, w.vertex};
                    if (idling_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 17);
                end
                s_axis_tvalid <= next_valid;
            end
        end
    end

    // output side
    always @(posedge i_clk) begin : bound_monitor
        logic [BOUND_W-1:0] want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bounds.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("bound word %0d arrived with none expected", m_axis_tdata);
                end else begin
                    want = expected_bounds.pop_front();
                    if (m_axis_tdata !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("bound mismatch: expected %0d, got %0d", want, m_axis_tdata);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 17);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("tb_landmark_distance_upper_bound_top failed");
        $finish;
    end

    initial begin : stimulus
        int n;
        int r;
        int cols;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: full-width scan over two filled rows
        fill_row(CMD_LOAD_TO, 0);
        fill_row(CMD_LOAD_FROM, VERTICES - 1);
        queue_query(0, VERTICES - 1);
        settle();

        // single column, widest cap
        write_reg(REG_LANDMARKS_USED, CFG_W'(1));
        write_reg(REG_DEFAULT_BOUND, 16'hFFFF);
        queue_load(CMD_LOAD_TO, 0, 0, 16'h7FFF);
        queue_load(CMD_LOAD_FROM, VERTICES - 1, 0, 16'h7FFF);
        queue_query(0, VERTICES - 1);                      // largest sum, just under cap
        queue_load(CMD_LOAD_TO, 0, 0, 16'hFFFF);
        queue_query(0, VERTICES - 1);                      // unknown leg
        queue_load(CMD_LOAD_TO, 0, 0, 16'h0000);
        queue_load(CMD_LOAD_FROM, VERTICES - 1, 0, 16'h0000);
        queue_query(0, VERTICES - 1);                      // zero path
        queue_load(CMD_LOAD_TO, 0, 0, 16'h8000);
        queue_query(0, VERTICES - 1);                      // most negative is unknown
        push_word(CMD_UNUSED, VERTICES - 1, LANDMARKS - 1, 16'hFFFF, VERTICES - 1);
        queue_load(CMD_LOAD_TO, 0, 0, 16'd100);
        queue_query(0, VERTICES - 1);
        settle();

        write_reg(REG_DEFAULT_BOUND, 16'h0000);            // cap of zero
        queue_query(0, VERTICES - 1);
        settle();
        write_reg(REG_LANDMARKS_USED, CFG_W'(0));          // no column scanned
        write_reg(REG_DEFAULT_BOUND, 16'd1234);
        queue_query(0, VERTICES - 1);
        settle();
        write_reg(REG_LANDMARKS_USED, CFG_W'(31));         // saturates to all columns
        write_reg(REG_DEFAULT_BOUND, 16'hFFFF);
        queue_load(CMD_LOAD_TO, 0, LANDMARKS - 1, 16'd5);
        queue_load(CMD_LOAD_FROM, VERTICES - 1, LANDMARKS - 1, 16'd7);
        queue_query(0, VERTICES - 1);

        // random phases; each one drains fully before its register writes
        while (item_total < ITEMS_TARGET) begin
            settle();
            idling_on = (item_total < CALM_AFTER) && ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 5);
            if (r == 0)      cols = 0;
            else if (r == 1) cols = LANDMARKS;
            else if (r == 2) cols = $urandom_range(LANDMARKS + 1, 31);
            else if (r == 3) cols = 1;
            else             cols = $urandom_range(1, LANDMARKS);
            write_reg(REG_LANDMARKS_USED, CFG_W'(cols));
            r = $urandom_range(0, 4);
            if (r == 0)      write_reg(REG_DEFAULT_BOUND, 16'h0000);
            else if (r == 1) write_reg(REG_DEFAULT_BOUND, 16'hFFFF);
            else if (r == 2) write_reg(REG_DEFAULT_BOUND, 16'($urandom_range(0, 2000)));
            else             write_reg(REG_DEFAULT_BOUND, 16'($urandom));

            if (to_ready.size() < 10 || $urandom_range(0, 3) == 0)
                fill_row(CMD_LOAD_TO, rand_vertex());
            if (from_ready.size() < 10 || $urandom_range(0, 3) == 0)
                fill_row(CMD_LOAD_FROM, rand_vertex());

            n = $urandom_range(30, 70);
            for (int k = 0; k < n; k++) begin
                r = $urandom_range(0, 19);
                if (r <= 9) begin
                    queue_query(pick_to(), pick_from());
                end else if (r <= 13) begin
                    // overwrite an entry of a filled row
                    if (r[0])
                        queue_load(CMD_LOAD_TO, pick_to(), $urandom_range(0, LANDMARKS - 1),
                                   rand_distance());
                    else
                        queue_load(CMD_LOAD_FROM, pick_from(),
                                   $urandom_range(0, LANDMARKS - 1), rand_distance());
                end else if (r <= 18) begin
                    queue_load(r[0] ? CMD_LOAD_TO : CMD_LOAD_FROM,
                               $urandom_range(0, VERTICES - 1),
                               $urandom_range(0, LANDMARKS - 1), 16'($urandom));
                end else begin
                    push_word(CMD_UNUSED, $urandom_range(0, VERTICES - 1),
                              $urandom_range(0, LANDMARKS - 1), 16'($urandom),
                              $urandom_range(0, VERTICES - 1));
                end
            end
        end

        settle();
        if (error_count == 0 && expected_bounds.size() == 0)
            $display("tb_landmark_distance_upper_bound_top passed");
        else
            $display("tb_landmark_distance_upper_bound_top failed");
        $finish;
    end

endmodule

/* landmark_distance_upper_bound_top.f */
design/ldub_pkg.sv
design/ldub_ram.sv
design/ldub_minacc.sv
design/landmark_distance_upper_bound_top.sv
tb/sv/tb_landmark_distance_upper_bound_top.sv
